// File: src/dq_pkg.sv
package dq_pkg;

	localparam int DQ_DEPTH = 16;
	localparam int DATA_W   = 32;
	localparam int MODE_W   = 3;
	localparam int POS_W    = 5;
	localparam int OCC_W    = 5;
	localparam int STATUS_W = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH_LEFT  = 3'd0,
		MODE_PUSH_RIGHT = 3'd1,
		MODE_POP_LEFT   = 3'd2,
		MODE_POP_RIGHT  = 3'd3,
		MODE_CLEAR      = 3'd4,
		MODE_SHOW       = 3'd5
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_PUSH_LEFT,
		DP_PUSH_RIGHT,
		DP_POP_LEFT,
		DP_POP_RIGHT,
		DP_CLEAR,
		DP_SHOW_START,
		DP_SHOW_NEXT,
		DP_RES_OK,
		DP_RES_EMPTY,
		DP_RES_FULL
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   capture;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic more;
	} sts_t;

endpackage

// File: src/dq_if.sv
interface dq_req_if;
	import dq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [MODE_W-1:0]        mode;
	logic signed [DATA_W-1:0] push_value;

	modport source (output valid, output mode, output push_value, input ready);
	modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface dq_rsp_if;
	import dq_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] data_value;
	logic [POS_W-1:0]         position;
	logic [OCC_W-1:0]         occupancy;
	logic [STATUS_W-1:0]      status;
	logic                     last_flag;

	modport source (output valid, output data_value, output position, output occupancy,
		output status, output last_flag, input ready);
	modport sink   (input valid, input data_value, input position, input occupancy,
		input status, input last_flag, output ready);
endinterface

// File: src/dq_ram.sv
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: src/dq_datapath.sv
module dq_datapath #(
	parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dq_pkg::cmd_t                     cmd,
	output dq_pkg::sts_t                     sts,
	input  logic signed [dq_pkg::DATA_W-1:0] push_value,
	output logic signed [dq_pkg::DATA_W-1:0] data_value,
	output logic [dq_pkg::POS_W-1:0]         position,
	output logic [dq_pkg::OCC_W-1:0]         occupancy,
	output logic [dq_pkg::STATUS_W-1:0]      status,
	output logic                             last_flag
);
	import dq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [AW-1:0]     left_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic [DATA_W-1:0] data_q;
	logic [CW-1:0]     pos_q;
	logic [CW-1:0]     occ_q;
	status_t           status_q;
	logic              last_q;

	logic              we;
	logic              re;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;
	logic [DATA_W-1:0] rdata;
	logic [AW-1:0]     dec_left;
	logic [CW-1:0]     count_m1;
	logic [CW-1:0]     count_p1;
	logic [CW-1:0]     idx_p1;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
		input logic [AW-1:0] off);
		logic [AW:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (AW + 1)'(DEPTH)) begin
			s = s - (AW + 1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign dec_left = (left_q == '0) ? AW'(DEPTH - 1) : left_q - 1'b1;
	assign count_m1 = count_q - 1'b1;
	assign count_p1 = count_q + 1'b1;
	assign idx_p1   = idx_q + 1'b1;

	assign sts.empty = (count_q == '0);
	assign sts.full  = (count_q == CW'(DEPTH));
	assign sts.more  = (idx_q != count_q);

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = left_q;
		raddr = left_q;
		unique case (cmd.op) inside
			DP_PUSH_LEFT: begin
				we    = 1'b1;
				waddr = dec_left;
			end
			DP_PUSH_RIGHT: begin
				we    = 1'b1;
				waddr = wrap_add(left_q, count_q[AW-1:0]);
			end
			DP_POP_LEFT, DP_SHOW_START: begin
				re = 1'b1;
			end
			DP_POP_RIGHT: begin
				re    = 1'b1;
				raddr = wrap_add(left_q, count_m1[AW-1:0]);
			end
			DP_SHOW_NEXT: begin
				re    = 1'b1;
				raddr = wrap_add(left_q, idx_q[AW-1:0]);
			end
			default: begin
			end
		endcase
	end

	dq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(push_value),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			unique case (cmd.op)
				DP_PUSH_LEFT: begin
					left_q  <= dec_left;
					count_q <= count_p1;
				end
				DP_PUSH_RIGHT: count_q <= count_p1;
				DP_POP_LEFT: begin
					left_q  <= wrap_add(left_q, AW'(1));
					count_q <= count_m1;
				end
				DP_POP_RIGHT:  count_q <= count_m1;
				DP_CLEAR:      count_q <= '0;
				DP_SHOW_START: idx_q   <= CW'(1);
				DP_SHOW_NEXT:  idx_q   <= idx_p1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			data_q <= rdata;
		end
		unique case (cmd.op) inside
			DP_PUSH_LEFT, DP_PUSH_RIGHT: begin
				data_q   <= '0;
				pos_q    <= '0;
				occ_q    <= count_p1;
				status_q <= STATUS_OK;
				last_q   <= 1'b1;
			end
			DP_POP_LEFT, DP_POP_RIGHT: begin
				pos_q    <= '0;
				occ_q    <= count_m1;
				status_q <= STATUS_OK;
				last_q   <= 1'b1;
			end
			DP_CLEAR: begin
				data_q   <= '0;
				pos_q    <= '0;
				occ_q    <= '0;
				status_q <= STATUS_OK;
				last_q   <= 1'b1;
			end
			DP_SHOW_START: begin
				pos_q    <= CW'(1);
				occ_q    <= count_q;
				status_q <= STATUS_OK;
				last_q   <= (count_q == CW'(1));
			end
			DP_SHOW_NEXT: begin
				pos_q  <= idx_p1;
				last_q <= (idx_p1 == count_q);
			end
			DP_RES_OK, DP_RES_EMPTY, DP_RES_FULL: begin
				data_q   <= '0;
				pos_q    <= '0;
				occ_q    <= count_q;
				status_q <= (cmd.op == DP_RES_EMPTY) ? STATUS_EMPTY :
					(cmd.op == DP_RES_FULL) ? STATUS_FULL : STATUS_OK;
				last_q   <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign data_value = data_q;
	assign position   = POS_W'(pos_q);
	assign occupancy  = OCC_W'(occ_q);
	assign status     = status_q;
	assign last_flag  = last_q;
endmodule

// File: src/dq_controller.sv
module dq_controller (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	input  logic [dq_pkg::MODE_W-1:0] req_mode,
	output logic                      req_ready,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output dq_pkg::cmd_t              cmd,
	input  dq_pkg::sts_t              sts
);
	import dq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_SEND
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   show_q;
	logic   show_d;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_SEND);

	always_comb begin
		cmd     = '{op: DP_NONE, capture: 1'b0};
		state_d = state_q;
		show_d  = show_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_SEND;
					unique case (req_mode) inside
						MODE_PUSH_LEFT:  cmd.op = sts.full ? DP_RES_FULL : DP_PUSH_LEFT;
						MODE_PUSH_RIGHT: cmd.op = sts.full ? DP_RES_FULL : DP_PUSH_RIGHT;
						MODE_POP_LEFT, MODE_POP_RIGHT, MODE_SHOW: begin
							if (sts.empty) begin
								cmd.op = DP_RES_EMPTY;
							end else begin
								state_d = S_FETCH;
								show_d  = (req_mode == MODE_SHOW);
								cmd.op  = (req_mode == MODE_SHOW) ? DP_SHOW_START :
									(req_mode == MODE_POP_LEFT) ? DP_POP_LEFT : DP_POP_RIGHT;
							end
						end
						MODE_CLEAR: cmd.op = DP_CLEAR;
						default:    cmd.op = DP_RES_OK;
					endcase
				end
			end
			S_FETCH: begin
				cmd.capture = 1'b1;
				state_d     = S_SEND;
			end
			S_SEND: begin
				if (rsp_ready) begin
					if (show_q && sts.more) begin
						cmd.op  = DP_SHOW_NEXT;
						state_d = S_FETCH;
					end else begin
						state_d = S_IDLE;
						show_d  = 1'b0;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			show_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			show_q  <= show_d;
		end
	end
endmodule

// File: src/double_ended_queue.sv
// Channel   Role    Payload
// req       sink    mode, push_value
// rsp       source  data_value, position, occupancy, status, last_flag
//
// Push, clear and refused transactions: result valid in the cycle after acceptance.
// Pop: the result waits on the registered read of the entry store, captured in S_FETCH.
// Show of N entries: per entry, a store read, then the result held until taken.
// One request at a time; req.ready is low while a result is pending or stalled.
// arst_n clears the pointers and count; the entry store is not cleared.
module double_ended_queue #(
	parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
	input logic clk,
	input logic arst_n,
	dq_req_if.sink   req,
	dq_rsp_if.source rsp
);
	import dq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	dq_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_mode (req.mode),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	dq_datapath #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.push_value(req.push_value),
		.data_value(rsp.data_value),
		.position  (rsp.position),
		.occupancy (rsp.occupancy),
		.status    (rsp.status),
		.last_flag (rsp.last_flag)
	);
endmodule

// File: src/dq_checker.sv
module dq_checker #(
	parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_ready,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic signed [dq_pkg::DATA_W-1:0] rsp_data_value,
	input logic [dq_pkg::POS_W-1:0]         rsp_position,
	input logic [dq_pkg::OCC_W-1:0]         rsp_occupancy,
	input logic [dq_pkg::STATUS_W-1:0]      rsp_status,
	input logic                             rsp_last_flag
);
	import dq_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_value)
			&& $stable(rsp_status) && $stable(rsp_last_flag))
		else $error("stalled transaction changed");

	a_no_req_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("request taken while a result is pending");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (int'(rsp_occupancy) <= DEPTH))
		else $error("occupancy beyond depth");

	a_refused_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != STATUS_OK) |-> rsp_last_flag
			&& (rsp_data_value == '0) && (rsp_position == '0))
		else $error("refused transaction malformed");
endmodule

bind double_ended_queue dq_checker #(.DEPTH(DEPTH)) u_dq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_data_value(rsp.data_value),
	.rsp_position  (rsp.position),
	.rsp_occupancy (rsp.occupancy),
	.rsp_status    (rsp.status),
	.rsp_last_flag (rsp.last_flag)
);
